// ----- hdl/sticky_session_load_balancer_defines.svh -----
// assertion macros for the sticky session load balancer
// no dependencies
`ifndef STICKY_SESSION_LOAD_BALANCER_DEFINES_SVH
`define STICKY_SESSION_LOAD_BALANCER_DEFINES_SVH
// implication checked on every edge outside reset
`define SSLB_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define SSLB_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// ----- hdl/sslb_pkg.sv -----
// package of the sticky session load balancer: sizes, codes, payload structs
// no dependencies
package sslb_pkg;
   localparam int SESSION_SLOTS = 64;
   localparam int BACKEND_SLOTS = 16;
   localparam int SLOT_W = $clog2(SESSION_SLOTS);
   localparam int KEY_W = 256;
   localparam logic [31:0] FRAME_MAGIC_OK = 32'h4C425346;
   localparam logic [29:0] NS_PER_SECOND = 30'd1000000000;

   localparam logic [1:0] ACT_PACKET = 2'd0;
   localparam logic [1:0] ACT_WRITE  = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   localparam logic [2:0] VERDICT_PASS  = 3'd0;
   localparam logic [2:0] VERDICT_REUSE = 3'd1;
   localparam logic [2:0] VERDICT_NEW   = 3'd2;
   localparam logic [2:0] VERDICT_DROP  = 3'd3;
   localparam logic [2:0] VERDICT_REG   = 3'd4;

   localparam logic [1:0] CSR_LB_ENABLED    = 2'd0;
   localparam logic [1:0] CSR_BACKEND_COUNT = 2'd1;
   localparam logic [1:0] CSR_BALANCE_MODE  = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT       = 2'd3;
   localparam logic [1:0] MODE_LEAST = 2'd1;

   // slot memory word: key, backend and last activity time
   localparam int SLOT_MEM_W = KEY_W + 4 + 64;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] cert_hash_0;
      logic [63:0] cert_hash_1;
      logic [63:0] cert_hash_2;
      logic [63:0] cert_hash_3;
      logic [63:0] now_ns;
      logic [15:0] byte_len;
      logic [31:0] frame_magic;
      logic [3:0]  backend_index;
      logic        backend_enable;
      logic        backend_healthy;
      logic [31:0] backend_limit;
   } req_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic [3:0]  chosen_backend;
      logic [31:0] conn_count;
      logic [63:0] request_count;
      logic [63:0] byte_count;
   } rsp_type;

   typedef struct packed {
      logic        enabled;
      logic        healthy;
      logic [31:0] max_conn;
      logic [31:0] conn;
      logic [63:0] requests;
      logic [63:0] bytes;
   } backend_type;
endpackage

// ----- hdl/sticky_session_load_balancer.sv -----
// Register actions and passed packets go straight to the result state; other packets pass a
// scan of the 64 session slots and a timeout multiply, then, unless a session is reused, a
// backend scan with least connections or an 8-step hash and a 32-step modulo; a dropped packet
// skips the commit. One transaction is in work at a time; the next request is taken at the
// edge where the result is taken, at the earliest.
// Reset (synchronous, active high) clears controls (backend count set to 1), slot valid bits and backend table.
// depends on sslb_pkg, sslb_ram and the defines header
`include "sticky_session_load_balancer_defines.svh"
module sticky_session_load_balancer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sslb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sslb_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wr_data
);
   import sslb_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_SCAN   = 10'b0000000010,
      ST_CHECK  = 10'b0000000100,
      ST_HASH   = 10'b0000001000,
      ST_MOD    = 10'b0000010000,
      ST_LEAST  = 10'b0000100000,
      ST_VERIFY = 10'b0001000000,
      ST_COMMIT = 10'b0010000000,
      ST_MULT   = 10'b0100000000,
      ST_OUT    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic lb_enabled_ff;
   logic [4:0] backend_count_ff;
   logic [1:0] balance_mode_ff;
   logic [31:0] timeout_ff;

   req_type req_ff;
   logic [SESSION_SLOTS-1:0] active_ff;
   logic [SLOT_W:0] scan_ff;
   logic [SLOT_W-1:0] hit_ff, free_ff;
   logic hit_found_ff, free_found_ff;
   logic [31:0] hash_ff, rem_ff;
   logic [4:0] step_ff;
   logic [3:0] pick_ff, best_ff;
   logic pick_oob_ff;
   logic [31:0] min_ff;
   logic [63:0] limit_ff;
   logic [2:0] verdict_ff;
   backend_type be_ff [BACKEND_SLOTS];

   logic rsp_valid_ff;
   rsp_type rsp_ff;

   // slot memory
   logic ram_we;
   logic [SLOT_W-1:0] ram_waddr, ram_raddr;
   logic [SLOT_MEM_W-1:0] ram_wdata, ram_rdata;
   logic [SLOT_W-1:0] scan_idx;
   logic [KEY_W-1:0] key_w;

   assign key_w = {req_ff.cert_hash_0, req_ff.cert_hash_1, req_ff.cert_hash_2,
                   req_ff.cert_hash_3};
   assign scan_idx = scan_ff[SLOT_W-1:0];
   assign ram_raddr = (state_ff == ST_SCAN) ? scan_idx : hit_ff;

   sslb_ram #(.WIDTH(SLOT_MEM_W), .DEPTH(SESSION_SLOTS)) u_slots (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
      .rd_addr(ram_raddr), .rd_data(ram_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE) && !(rsp_valid_ff && !rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // scan compare on the previous read (address scan_ff-1)
   logic [SLOT_W-1:0] prev_idx;
   logic prev_act, prev_match;
   assign prev_idx = scan_idx - SLOT_W'(1);
   assign prev_act = active_ff[prev_idx];
   assign prev_match = prev_act && (ram_rdata[SLOT_MEM_W-1 -: KEY_W] == key_w);

   logic [63:0] age;
   assign age = req_ff.now_ns - ram_rdata[63:0];

   logic [3:0] bi;
   assign bi = pick_ff;
   logic be_ok;
   assign be_ok = !pick_oob_ff && be_ff[bi].enabled && be_ff[bi].healthy &&
                  (be_ff[bi].conn < be_ff[bi].max_conn);

   logic [32:0] rem_sh;
   assign rem_sh = {rem_ff, hash_ff[31]};

   // final remainder step of the modulo
   logic [4:0] mod_rem;
   assign mod_rem = (rem_sh >= {28'd0, backend_count_ff}) ?
                    5'(rem_sh - {28'd0, backend_count_ff}) : rem_sh[4:0];

   // main control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lb_enabled_ff <= 1'b0;
         backend_count_ff <= 5'd1;
         balance_mode_ff <= 2'd0;
         timeout_ff <= 32'd0;
         active_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < BACKEND_SLOTS; i++) be_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_LB_ENABLED:    lb_enabled_ff <= csr_wr_data[0];
               CSR_BACKEND_COUNT: backend_count_ff <= csr_wr_data[4:0];
               CSR_BALANCE_MODE:  balance_mode_ff <= csr_wr_data[1:0];
               CSR_TIMEOUT:       timeout_ff <= csr_wr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  req_ff <= req_data;
                  scan_ff <= '0;
                  hit_found_ff <= 1'b0;
                  free_found_ff <= 1'b0;
                  hit_ff <= '0;
                  free_ff <= '0;
                  pick_oob_ff <= 1'b0;
                  step_ff <= '0;
                  hash_ff <= '0;
                  limit_ff <= '0;
               end
            end
            ST_SCAN: begin
               scan_ff <= scan_ff + 1'b1;
               if (scan_ff != '0 && !hit_found_ff) begin
                  if (prev_match) begin
                     hit_found_ff <= 1'b1;
                     hit_ff <= prev_idx;
                  end
                  if (!prev_act && !free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_ff <= prev_idx;
                  end
               end
            end
            ST_MULT: begin
               // limit = timeout * 1e9, shift-add over the 32 bits of the timeout
               step_ff <= step_ff + 1'b1;
               if (timeout_ff[step_ff])
                  limit_ff <= limit_ff + ({34'd0, NS_PER_SECOND} << step_ff);
            end
            ST_CHECK: begin
               if (hit_found_ff && age < limit_ff) begin
                  verdict_ff <= VERDICT_REUSE;
                  pick_ff <= ram_rdata[67:64];
               end else if (hit_found_ff) begin
                  // expired session frees its slot
                  active_ff[hit_ff] <= 1'b0;
                  hit_found_ff <= 1'b0;
                  if (!free_found_ff || hit_ff < free_ff) begin
                     free_found_ff <= 1'b1;
                     free_ff <= hit_ff;
                  end
               end
               step_ff <= '0;
               best_ff <= '0;
               min_ff <= 32'hFFFFFFFF;
            end
            ST_HASH: begin
               // step counter restarts for the modulo
               step_ff <= (step_ff == 5'd7) ? 5'd0 : step_ff + 1'b1;
               hash_ff <= hash_ff * 32'd31 +
                          {24'd0, req_ff.cert_hash_0[63 - 8*step_ff[2:0] -: 8]};
               rem_ff <= '0;
            end
            ST_MOD: begin
               // restoring division one quotient bit per cycle
               step_ff <= step_ff + 1'b1;
               hash_ff <= {hash_ff[30:0], 1'b0};
               if (rem_sh >= {28'd0, backend_count_ff})
                  rem_ff <= 32'(rem_sh - {28'd0, backend_count_ff});
               else rem_ff <= rem_sh[31:0];
            end
            ST_LEAST: begin
               step_ff <= step_ff + 1'b1;
               if ({1'b0, step_ff[3:0]} < backend_count_ff &&
                   be_ff[step_ff[3:0]].enabled && be_ff[step_ff[3:0]].healthy &&
                   be_ff[step_ff[3:0]].conn < be_ff[step_ff[3:0]].max_conn &&
                   be_ff[step_ff[3:0]].conn < min_ff) begin
                  min_ff <= be_ff[step_ff[3:0]].conn;
                  best_ff <= step_ff[3:0];
               end
            end
            ST_VERIFY: ;
            ST_COMMIT: begin
               be_ff[pick_ff].requests <= be_ff[pick_ff].requests + 64'd1;
               be_ff[pick_ff].bytes <= be_ff[pick_ff].bytes +
                                        {48'd0, req_ff.byte_len};
               if (verdict_ff == VERDICT_NEW) begin
                  be_ff[pick_ff].conn <= be_ff[pick_ff].conn + 32'd1;
                  if (free_found_ff) active_ff[free_ff] <= 1'b1;
               end
            end
            ST_OUT: ;
            default: ;
         endcase
         // result register and register actions
         if (state_ff == ST_OUT) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff.verdict <= verdict_ff;
            rsp_ff.chosen_backend <= pick_ff;
            if (verdict_ff == VERDICT_PASS || pick_oob_ff) begin
               rsp_ff.conn_count <= '0;
               rsp_ff.request_count <= '0;
               rsp_ff.byte_count <= '0;
            end else begin
               rsp_ff.conn_count <= be_ff[pick_ff].conn;
               rsp_ff.request_count <= be_ff[pick_ff].requests;
               rsp_ff.byte_count <= be_ff[pick_ff].bytes;
            end
         end else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_IDLE && req_valid && req_ready) begin
            if (req_data.action == ACT_WRITE) begin
               be_ff[req_data.backend_index].enabled <= req_data.backend_enable;
               be_ff[req_data.backend_index].healthy <= req_data.backend_healthy;
               be_ff[req_data.backend_index].max_conn <= req_data.backend_limit;
            end
            if (req_data.action == ACT_WRITE || req_data.action == ACT_READ) begin
               verdict_ff <= VERDICT_REG;
               pick_ff <= req_data.backend_index;
            end else if (req_data.action != ACT_PACKET || !lb_enabled_ff ||
                         req_data.frame_magic != FRAME_MAGIC_OK) begin
               verdict_ff <= VERDICT_PASS;
               pick_ff <= '0;
            end else verdict_ff <= VERDICT_NEW;
         end
         // hashed pick beyond the backend table finds no backend
         if (state_ff == ST_MOD && step_ff == 5'd31) begin
            pick_ff <= (backend_count_ff == 5'd0 || mod_rem[4]) ? 4'd0 : mod_rem[3:0];
            pick_oob_ff <= (backend_count_ff != 5'd0) && mod_rem[4];
         end
         if (state_ff == ST_LEAST && step_ff == 5'd15) begin
            pick_ff <= ({1'b0, step_ff[3:0]} < backend_count_ff &&
                        be_ff[15].enabled && be_ff[15].healthy &&
                        be_ff[15].conn < be_ff[15].max_conn &&
                        be_ff[15].conn < min_ff) ? 4'd15 : best_ff;
         end
         if (state_ff == ST_VERIFY && !be_ok) verdict_ff <= VERDICT_DROP;
      end
   end

   // slot write on commit of a new session, refresh on reuse
   always_comb begin
      ram_we = 1'b0;
      ram_waddr = free_ff;
      ram_wdata = {key_w, pick_ff, req_ff.now_ns};
      if (state_ff == ST_COMMIT) begin
         if (verdict_ff == VERDICT_NEW && free_found_ff) ram_we = 1'b1;
         if (verdict_ff == VERDICT_REUSE) begin
            ram_we = 1'b1;
            ram_waddr = hit_ff;
            ram_wdata = {ram_rdata[SLOT_MEM_W-1:64], req_ff.now_ns};
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid && req_ready) begin
            if (req_data.action == ACT_PACKET && lb_enabled_ff &&
                req_data.frame_magic == FRAME_MAGIC_OK) state_in = ST_SCAN;
            else state_in = ST_OUT;
         end
         ST_SCAN: if (scan_ff == SESSION_SLOTS[SLOT_W:0]) state_in = ST_MULT;
         ST_MULT: if (step_ff == 5'd31) state_in = ST_CHECK;
         ST_CHECK: begin
            if (hit_found_ff && age < limit_ff) state_in = ST_COMMIT;
            else if (balance_mode_ff == MODE_LEAST) state_in = ST_LEAST;
            else state_in = ST_HASH;
         end
         ST_HASH: if (step_ff == 5'd7) state_in = ST_MOD;
         ST_MOD: if (step_ff == 5'd31) state_in = ST_VERIFY;
         ST_LEAST: if (step_ff == 5'd15) state_in = ST_VERIFY;
         ST_VERIFY: state_in = be_ok ? ST_COMMIT : ST_OUT;
         ST_COMMIT: state_in = ST_OUT;
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   `SSLB_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE)
   `SSLB_ASSERT_NEXT(a_out_valid, clock, reset, state_ff == ST_OUT, rsp_valid)
   `SSLB_ASSERT_IMP(a_commit_ok, clock, reset, state_ff == ST_COMMIT,
      verdict_ff == VERDICT_NEW || verdict_ff == VERDICT_REUSE)
endmodule

// ----- hdl/sslb_ram.sv -----
// generic single-port-write ram with registered read
// no dependencies
module sslb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- tb/sticky_session_load_balancer_tb.sv -----
// testbench of the sticky session load balancer: directed table, random traffic, scoreboard
// depends on sslb_pkg and the sticky_session_load_balancer top level
module sticky_session_load_balancer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sslb_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;
   localparam logic [1:0] ACT_NONE = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic [1:0]  csr_index;
   logic [31:0] csr_wr_data;

   sticky_session_load_balancer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   // balancer state mirror
   logic        lb_on;
   logic [4:0]  n_backends;
   logic [1:0]  mode;
   logic [31:0] idle_sec;
   logic        sess_live [SESSION_SLOTS];
   logic [255:0] sess_key [SESSION_SLOTS];
   logic [3:0]  sess_be [SESSION_SLOTS];
   logic [63:0] sess_seen [SESSION_SLOTS];
   backend_type be_tab [BACKEND_SLOTS];

   rsp_type expected_rsps[$];
   int      errors;
   int      accepted;
   int      n_reuse, n_new, n_drop;
   int      idle_cnt;
   logic    quiet;
   logic    done;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic rsp_type counters_of(logic [2:0] v, int b);
      rsp_type r;
      r.verdict = v;
      r.chosen_backend = b[3:0];
      r.conn_count = be_tab[b].conn;
      r.request_count = be_tab[b].requests;
      r.byte_count = be_tab[b].bytes;
      return r;
   endfunction

   // compute the balancer's answer to one transaction and update the mirror
   function automatic rsp_type balance_packet(req_type q);
      rsp_type r;
      logic [255:0] key;
      int hit, b, s;
      logic [31:0] h, best_conn;
      logic [63:0] lim;
      r = '0;
      key = {q.cert_hash_0, q.cert_hash_1, q.cert_hash_2, q.cert_hash_3};
      if (q.action == ACT_WRITE || q.action == ACT_READ) begin
         if (q.action == ACT_WRITE) begin
            be_tab[q.backend_index].enabled = q.backend_enable;
            be_tab[q.backend_index].healthy = q.backend_healthy;
            be_tab[q.backend_index].max_conn = q.backend_limit;
         end
         return counters_of(VERDICT_REG, q.backend_index);
      end
      if (q.action != ACT_PACKET || !lb_on || q.frame_magic != FRAME_MAGIC_OK) return r;
      hit = -1;
      for (s = 0; s < SESSION_SLOTS; s++)
         if (hit < 0 && sess_live[s] && sess_key[s] == key) hit = s;
      if (hit >= 0) begin
         lim = 64'(idle_sec) * 64'd1000000000;
         if (q.now_ns - sess_seen[hit] < lim) begin
            sess_seen[hit] = q.now_ns;
            b = sess_be[hit];
            r.verdict = VERDICT_REUSE;
         end else begin
            sess_live[hit] = 1'b0;
            hit = -1;
         end
      end
      if (hit < 0) begin
         if (mode == MODE_LEAST) begin
            b = 0;
            best_conn = 32'hFFFFFFFF;
            for (int i = 0; i < BACKEND_SLOTS && i < n_backends; i++)
               if (be_tab[i].enabled && be_tab[i].healthy &&
                   be_tab[i].conn < be_tab[i].max_conn && be_tab[i].conn < best_conn) begin
                  best_conn = be_tab[i].conn;
                  b = i;
               end
         end else begin
            h = '0;
            for (int i = 0; i < 8; i++) h = h * 32'd31 + q.cert_hash_0[63 - 8 * i -: 8];
            b = (n_backends == 0) ? 0 : int'(h % 32'(n_backends));
         end
         // no backend there: dropped with everything else zero
         if (b >= BACKEND_SLOTS) begin
            r.verdict = VERDICT_DROP;
            return r;
         end
         if (!be_tab[b].enabled || !be_tab[b].healthy || be_tab[b].conn >= be_tab[b].max_conn)
            return counters_of(VERDICT_DROP, b);
         for (s = 0; s < SESSION_SLOTS; s++)
            if (!sess_live[s]) begin
               sess_live[s] = 1'b1;
               sess_key[s] = key;
               sess_be[s] = b[3:0];
               sess_seen[s] = q.now_ns;
               break;
            end
         be_tab[b].conn++;
         r.verdict = VERDICT_NEW;
      end
      be_tab[b].requests++;
      be_tab[b].bytes += 64'(q.byte_len);
      return counters_of(r.verdict, b);
   endfunction

   // configuration write, mirrored
   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_LB_ENABLED:    lb_on = val[0];
         CSR_BACKEND_COUNT: n_backends = val[4:0];
         CSR_BALANCE_MODE:  mode = val[1:0];
         default:           idle_sec = val;
      endcase
   endtask

   task automatic wait_drained();
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // one transaction on the request channel, driven at the falling edge
   task automatic send_req(req_type q, logic has_golden, rsp_type golden);
      rsp_type p;
      @(negedge clock);
      if (!quiet)
         while ($urandom_range(99) < 9) @(negedge clock);
      p = balance_packet(q);
      if (has_golden && p != golden) begin
         errors++;
         $display("%0t directed row: expected %h, predictor %h", $time, golden, p);
      end
      req_data <= q;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsps.push_back(p);
      accepted++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic req_type packet(logic [255:0] key, logic [63:0] t, logic [15:0] len);
      req_type q;
      q = '0;
      q.action = ACT_PACKET;
      {q.cert_hash_0, q.cert_hash_1, q.cert_hash_2, q.cert_hash_3} = key;
      q.now_ns = t;
      q.byte_len = len;
      q.frame_magic = FRAME_MAGIC_OK;
      return q;
   endfunction

   function automatic req_type be_access(logic [1:0] act, logic [3:0] idx, logic en,
                                         logic hl, logic [31:0] lim);
      req_type q;
      q = '0;
      q.action = act;
      q.backend_index = idx;
      q.backend_enable = en;
      q.backend_healthy = hl;
      q.backend_limit = lim;
      return q;
   endfunction

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   // response checking and acceptance watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("%0t unexpected response %h", $time, rsp_data);
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_data.verdict == VERDICT_REUSE) n_reuse++;
               if (rsp_data.verdict == VERDICT_NEW) n_new++;
               if (rsp_data.verdict == VERDICT_DROP) n_drop++;
               if (rsp_data.verdict !== e.verdict || rsp_data.chosen_backend !== e.chosen_backend ||
                   rsp_data.conn_count !== e.conn_count ||
                   rsp_data.request_count !== e.request_count ||
                   rsp_data.byte_count !== e.byte_count) begin
                  errors++;
                  $display("%0t mismatch: expected v%0d b%0d c%0d r%0d y%0d, got v%0d b%0d c%0d r%0d y%0d",
                     $time, e.verdict, e.chosen_backend, e.conn_count, e.request_count,
                     e.byte_count, rsp_data.verdict, rsp_data.chosen_backend,
                     rsp_data.conn_count, rsp_data.request_count, rsp_data.byte_count);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cnt <= 0;
         else idle_cnt <= idle_cnt + 1;
         if (idle_cnt >= WATCHDOG_LIMIT && !done) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 9);
   end

   typedef struct {
      req_type q;
      logic    has_golden;
      rsp_type golden;
   } stim_row;

   stim_row rows[$];
   logic [255:0] keys [8];
   logic [255:0] k_all1;

   initial begin
      rsp_type z;
      stim_row row;
      req_type q;
      logic [63:0] clk_ns;
      int k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_LB_ENABLED;
      csr_wr_data = '0;
      errors = 0; accepted = 0; n_reuse = 0; n_new = 0; n_drop = 0;
      idle_cnt = 0; quiet = 1'b0; done = 1'b0;
      lb_on = 1'b0; n_backends = 5'd1; mode = 2'd0; idle_sec = '0;
      for (int i = 0; i < SESSION_SLOTS; i++) begin
         sess_live[i] = 1'b0; sess_key[i] = '0; sess_be[i] = '0; sess_seen[i] = '0;
      end
      for (int i = 0; i < BACKEND_SLOTS; i++) be_tab[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      z = '0;
      k_all1 = '1;

      // directed table
      row.has_golden = 1'b1; row.golden = z;
      row.q = packet(k_all1, '1, 16'hFFFF); rows.push_back(row);   // balancer off: pass
      row.q = be_access(ACT_NONE, 4'hF, 1, 1, '1); rows.push_back(row); // unused action
      row.golden = z; row.golden.verdict = VERDICT_REG; row.golden.chosen_backend = 4'hF;
      row.q = be_access(ACT_READ, 4'hF, 0, 0, 0); rows.push_back(row);
      row.golden.chosen_backend = 4'h0;
      row.q = be_access(ACT_WRITE, 4'h0, 1, 1, 32'hFFFFFFFF); rows.push_back(row);
      row.has_golden = 1'b0;
      for (int i = 1; i < 16; i++) begin
         row.q = be_access(ACT_WRITE, i[3:0], i != 3, i != 5, (i == 7) ? 32'd0 : 32'd1000);
         rows.push_back(row);
      end
      foreach (rows[i]) send_req(rows[i].q, rows[i].has_golden, rows[i].golden);
      rows.delete();
      wait_drained();

      write_csr(CSR_LB_ENABLED, 32'd1);
      write_csr(CSR_BACKEND_COUNT, 32'd16);
      write_csr(CSR_BALANCE_MODE, 32'd0);
      write_csr(CSR_TIMEOUT, 32'd0);
      // zero timeout: repeated key is always new; wrong magic passes
      send_req(packet('0, 0, 0), 0, z);
      send_req(packet('0, 64'd5, 16'd1), 0, z);
      q = packet(k_all1, '1, 16'hFFFF); q.frame_magic = ~FRAME_MAGIC_OK;
      send_req(q, 1, z);
      wait_drained();
      write_csr(CSR_TIMEOUT, 32'hFFFFFFFF);
      write_csr(CSR_BACKEND_COUNT, 32'd0);   // hash picks backend 0
      send_req(packet(k_all1, 64'd100, 16'hFFFF), 0, z);
      send_req(packet(k_all1, 64'd200, 16'd7), 0, z);  // reuse
      send_req(packet({64'd1, 192'd0}, 64'd300, 16'd3), 0, z);
      wait_drained();
      write_csr(CSR_BALANCE_MODE, 32'd1);
      write_csr(CSR_BACKEND_COUNT, 32'd31);  // beyond backends: scan clips
      send_req(packet({64'd2, 192'd5}, 64'd400, 16'd9), 0, z);
      wait_drained();
      // hash lands on backend 20 of 31: no such backend, dropped with zero counters
      write_csr(CSR_BALANCE_MODE, 32'd0);
      row.golden = z; row.golden.verdict = VERDICT_DROP;
      send_req(packet({64'd20, 192'd0}, 64'd500, 16'd4), 1, row.golden);
      wait_drained();

      // random phases
      clk_ns = 64'd1000;
      for (int i = 0; i < 8; i++) keys[i] = {rnd64(), rnd64(), rnd64(), rnd64()};
      for (int ph = 0; ph < 10; ph++) begin
         write_csr(CSR_LB_ENABLED, (ph == 4) ? 32'd0 : 32'd1);
         write_csr(CSR_BACKEND_COUNT, (ph == 9) ? 32'd1 : 32'($urandom_range(1, 16)));
         write_csr(CSR_BALANCE_MODE, 32'(ph % 3));
         write_csr(CSR_TIMEOUT, (ph == 2) ? 32'd0 : (ph == 6) ? 32'hFFFFFFFF :
                   32'($urandom_range(1, 5)));
         quiet = (ph == 3);
         for (int j = 0; j < 200; j++) begin
            k = $urandom_range(99);
            if (k < 8) begin
               q = be_access(ACT_WRITE, 4'($urandom), $urandom_range(99) < 85,
                             $urandom_range(99) < 85,
                             ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 300));
            end else if (k < 14) begin
               q = be_access(ACT_READ, 4'($urandom), 0, 0, 0);
            end else if (k < 17) begin
               q = '0;
               q.action = 2'($urandom);
               {q.cert_hash_0, q.cert_hash_1, q.cert_hash_2, q.cert_hash_3, q.now_ns} =
                  {rnd64(), rnd64(), rnd64(), rnd64(), rnd64()};
               q.byte_len = 16'($urandom); q.frame_magic = $urandom;
               {q.backend_index, q.backend_enable, q.backend_healthy} = 6'($urandom);
               q.backend_limit = $urandom;
            end else begin
               // sessions: mostly a small reused key pool, time moving forward in random steps
               clk_ns += 64'($urandom_range(0, 1500000000));
               if ($urandom_range(99) < 2) clk_ns = rnd64();
               q = packet(($urandom_range(99) < 70) ? keys[$urandom_range(7)] :
                          {rnd64(), rnd64(), rnd64(), rnd64()}, clk_ns, 16'($urandom));
               if ($urandom_range(99) < 4) q.frame_magic = $urandom;
            end
            send_req(q, 0, z);
         end
         // sender holds off until all responses are back
         wait_drained();
      end

      wait_drained();
      done = 1'b1;
      $display("covered %0d transactions: %0d reused, %0d new, %0d dropped sessions",
               accepted, n_reuse, n_new, n_drop);
      $display("register settings swept: enable, backend counts 0..31, all modes, timeouts");
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
